// ===== design/fsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fsw_pkg;

    // Sizing
    localparam int MaxSectors = 64;
    localparam int IdxW       = $clog2(MaxSectors);
    localparam int TrkW       = $clog2(MaxSectors + 1);
    localparam int DataW      = 32;
    localparam int DivW       = DataW + 8;             // holds count * 100
    localparam int DivCntW    = $clog2(DivW);
    localparam int CfgIdxW    = 3;
    localparam int HealthW    = 7;

    // Health scale
    localparam logic [HealthW-1:0] HealthFull = HealthW'(100);

    // Register reset values
    localparam logic [DataW-1:0] RstWindowBase  = DataW'(0);
    localparam logic [DataW-1:0] RstWindowSize  = DataW'(524288);
    localparam logic [DataW-1:0] RstSectorBytes = DataW'(8192);
    localparam logic [TrkW-1:0]  RstTracked     = TrkW'(64);
    localparam logic [DataW-1:0] RstRated       = DataW'(10000);

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_WINDOW_BASE     = 3'd0,
        REG_WINDOW_SIZE     = 3'd1,
        REG_SECTOR_BYTES    = 3'd2,
        REG_TRACKED_SECTORS = 3'd3,
        REG_RATED_CYCLES    = 3'd4
    } t_reg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_COUNTED = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    typedef struct packed {
        logic [DataW-1:0] window_base;
        logic [DataW-1:0] window_size;
        logic [DataW-1:0] sector_bytes;
        logic [TrkW-1:0]  tracked;
        logic [DataW-1:0] rated;
    } t_cfg;

    typedef struct packed {
        logic             rd_en;
        logic [IdxW-1:0]  rd_addr;
        logic             wr_en;
        logic [IdxW-1:0]  wr_addr;
        logic [DataW-1:0] wr_data;
    } t_mem_req;

    typedef struct packed {
        logic             start;
        logic [DivW-1:0]  dividend;
        logic [DataW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        t_status            status;
        logic [DataW-1:0]   sector_num;
        logic [DataW-1:0]   sector_count_now;
        logic [DataW-1:0]   worst_count;
        logic [DataW-1:0]   least_count;
        logic [DataW-1:0]   erase_total;
        logic [HealthW-1:0] health;
    } t_result;

endpackage

`default_nettype wire

// ===== design/fsw_erase_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fsw_erase_if;
    logic                         valid;
    logic                         ready;
    logic [fsw_pkg::DataW-1:0]    erase_address;

    modport source (output valid, output erase_address, input ready);
    modport sink   (input valid, input erase_address, output ready);
endinterface

`default_nettype wire

// ===== design/fsw_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface fsw_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [fsw_pkg::DataW-1:0]    sector_num;
    logic [fsw_pkg::DataW-1:0]    sector_count_now;
    logic [fsw_pkg::DataW-1:0]    worst_count;
    logic [fsw_pkg::DataW-1:0]    least_count;
    logic [fsw_pkg::DataW-1:0]    erase_total;
    logic [fsw_pkg::HealthW-1:0]  health;

    modport source (output valid, output status, output sector_num,
                    output sector_count_now, output worst_count, output least_count,
                    output erase_total, output health, input ready);
    modport sink   (input valid, input status, input sector_num,
                    input sector_count_now, input worst_count, input least_count,
                    input erase_total, input health, output ready);
endinterface

`default_nettype wire

// ===== design/flash_sector_wear_tracker_unit.sv =====
// Flash sector wear tracker.
// Input channel i_erase carries one item per completed sector erase (erase_address).
// Output channel o_result returns exactly one item per input item: status, sector
// index, the sector's new count, worst/least counts over tracked sectors, total
// erases and health percent. Both channels use a valid/ready handshake.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 window base,
// 1 window size, 2 sector bytes, 3 tracked sectors, 4 rated cycles); write only
// while no item is in flight.
// One item is in work at a time; the next is taken once the last result has moved
// to the output register. A counted erase makes two passes of the shared serial
// divider (sector index, then usage percent), with window check, range check,
// counter read, update and a counter-RAM rescan of the tracked sectors between.
// With rated cycles at 0 the second pass is skipped, with sector bytes at 0 the first.
// An outside address skips passes and rescan; a sector past the tracked count skips the update, rescan and second pass.
// Reset (synchronous, active low) restores register defaults, zeroes all counters
// and statistics, and sets health to 100; no clearing pass is needed.
// The result sits in an output register; while the receiver stalls, the next item
// is still accepted and worked on, and waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none

module flash_sector_wear_tracker_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [fsw_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire [fsw_pkg::DataW-1:0]       i_cfg_data,
    fsw_erase_if.sink                      i_erase,
    fsw_result_if.source                   o_result
);

    fsw_pkg::t_cfg      r_cfg;
    logic               r_out_vld;
    fsw_pkg::t_result   r_out;

    logic               seq_idle;
    logic               res_vld;
    logic               res_rdy;
    fsw_pkg::t_result   res;
    fsw_pkg::t_mem_req  mem_req;
    logic [fsw_pkg::DataW-1:0] mem_rdata;
    fsw_pkg::t_div_req  div_req;
    fsw_pkg::t_div_rsp  div_rsp;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_base  <= fsw_pkg::RstWindowBase;
            r_cfg.window_size  <= fsw_pkg::RstWindowSize;
            r_cfg.sector_bytes <= fsw_pkg::RstSectorBytes;
            r_cfg.tracked      <= fsw_pkg::RstTracked;
            r_cfg.rated        <= fsw_pkg::RstRated;
        end else if (i_cfg_we) begin
            case (fsw_pkg::t_reg_idx'(i_cfg_idx))
                fsw_pkg::REG_WINDOW_BASE:     r_cfg.window_base  <= i_cfg_data;
                fsw_pkg::REG_WINDOW_SIZE:     r_cfg.window_size  <= i_cfg_data;
                fsw_pkg::REG_SECTOR_BYTES:    r_cfg.sector_bytes <= i_cfg_data;
                fsw_pkg::REG_TRACKED_SECTORS: r_cfg.tracked <= i_cfg_data[fsw_pkg::TrkW-1:0];
                fsw_pkg::REG_RATED_CYCLES:    r_cfg.rated        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register
    assign res_rdy = !r_out_vld || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign i_erase.ready             = seq_idle;
    assign o_result.valid            = r_out_vld;
    assign o_result.status           = r_out.status;
    assign o_result.sector_num       = r_out.sector_num;
    assign o_result.sector_count_now = r_out.sector_count_now;
    assign o_result.worst_count      = r_out.worst_count;
    assign o_result.least_count      = r_out.least_count;
    assign o_result.erase_total      = r_out.erase_total;
    assign o_result.health           = r_out.health;

    fsw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (i_erase.valid && seq_idle),
        .i_addr      (i_erase.erase_address),
        .o_idle      (seq_idle),
        .o_res_vld   (res_vld),
        .i_res_rdy   (res_rdy),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    fsw_cnt_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (mem_rdata)
    );

    fsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

`default_nettype wire

// ===== design/fsw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module fsw_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  fsw_pkg::t_div_req  i_req,
    output fsw_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [fsw_pkg::DivCntW-1:0]   r_cnt;
    logic [fsw_pkg::DivW-1:0]      r_quo;
    logic [fsw_pkg::DataW-1:0]     r_rem;
    logic [fsw_pkg::DataW-1:0]     r_dsr;

    logic [fsw_pkg::DataW:0]       shifted;
    logic [fsw_pkg::DataW:0]       diff;
    logic                          fits;
    logic [fsw_pkg::DataW-1:0]     n_rem;

    // Trial subtract of one step
    always_comb begin
        shifted = {r_rem, r_quo[fsw_pkg::DivW-1]};
        diff    = shifted - {1'b0, r_dsr};
        fits    = (shifted >= {1'b0, r_dsr});
        n_rem   = fits ? diff[fsw_pkg::DataW-1:0] : shifted[fsw_pkg::DataW-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fsw_pkg::DivCntW'(fsw_pkg::DivW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[fsw_pkg::DivW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/fsw_cnt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-sector erase counters: one read and one write port, registered read
module fsw_cnt_mem (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  fsw_pkg::t_mem_req           i_req,
    output logic [fsw_pkg::DataW-1:0]   o_rd_data
);

    logic [fsw_pkg::DataW-1:0]       r_mem [fsw_pkg::MaxSectors];
    logic [fsw_pkg::MaxSectors-1:0]  r_vld;
    logic [fsw_pkg::DataW-1:0]       r_rd_raw;
    logic                            r_rd_ok;

    // Storage and read register
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_raw <= r_mem[i_req.rd_addr];
        end
    end

    // Entry valid bits: an unwritten counter reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_raw : '0;

endmodule

`default_nettype wire

// ===== design/fsw_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-item sequencer: window check, index divide, counter update, rescan, health
module fsw_seq (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  fsw_pkg::t_cfg               i_cfg,
    input  wire                         i_accept,
    input  wire [fsw_pkg::DataW-1:0]    i_addr,
    output logic                        o_idle,
    output logic                        o_res_vld,
    input  wire                         i_res_rdy,
    output fsw_pkg::t_result            o_res,
    output fsw_pkg::t_mem_req           o_mem_req,
    input  wire [fsw_pkg::DataW-1:0]    i_mem_rdata,
    output fsw_pkg::t_div_req           o_div_req,
    input  fsw_pkg::t_div_rsp           i_div_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_IDIV,
        S_RANGE,
        S_READ,
        S_UPD,
        S_SCAN,
        S_HDIV,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [fsw_pkg::DataW-1:0]       r_addr;
    fsw_pkg::t_status                r_status;
    logic [fsw_pkg::DataW-1:0]       r_idx;
    logic [fsw_pkg::DataW-1:0]       r_now;
    logic [fsw_pkg::DataW-1:0]       r_total;
    logic [fsw_pkg::DataW-1:0]       r_max;
    logic [fsw_pkg::DataW-1:0]       r_min;
    logic [fsw_pkg::HealthW-1:0]     r_health;
    logic [fsw_pkg::TrkW-1:0]        r_scan;
    logic                            r_acc_vld;
    logic [fsw_pkg::DataW-1:0]       r_hi;
    logic [fsw_pkg::DataW-1:0]       r_lo;

    logic [fsw_pkg::TrkW-1:0]        eff_tracked;
    logic [fsw_pkg::DataW:0]         win_end;
    logic                            outside;
    logic [fsw_pkg::DataW-1:0]       offset;
    logic                            scan_issue;
    logic                            scan_done;
    logic [fsw_pkg::DivW-1:0]        usage_num;
    logic [fsw_pkg::DivW-1:0]        usage;
    logic [fsw_pkg::HealthW-1:0]     health_calc;

    // Window and tracked-count decode
    always_comb begin
        eff_tracked = (i_cfg.tracked > fsw_pkg::TrkW'(fsw_pkg::MaxSectors))
                    ? fsw_pkg::TrkW'(fsw_pkg::MaxSectors) : i_cfg.tracked;
        win_end     = {1'b0, i_cfg.window_base} + {1'b0, i_cfg.window_size};
        outside     = (r_addr < i_cfg.window_base) || ({1'b0, r_addr} >= win_end);
        offset      = r_addr - i_cfg.window_base;
        scan_issue  = (r_state == S_SCAN) && (r_scan < eff_tracked);
        scan_done   = (r_state == S_SCAN) && (r_scan == eff_tracked) && !r_acc_vld;
    end

    // Worst count times 100 as shifts and adds
    always_comb begin
        usage_num = (fsw_pkg::DivW'(r_hi) << 6) + (fsw_pkg::DivW'(r_hi) << 5)
                  + (fsw_pkg::DivW'(r_hi) << 2);
        usage     = i_div_rsp.quotient;
        health_calc = (usage > fsw_pkg::DivW'(fsw_pkg::HealthFull)) ? '0
                    : fsw_pkg::HealthFull - usage[fsw_pkg::HealthW-1:0];
    end

    // Memory and divider requests
    always_comb begin
        o_mem_req = '0;
        o_div_req = '0;
        case (r_state)
            S_CHECK: begin
                if (!outside && (i_cfg.sector_bytes != '0)) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = fsw_pkg::DivW'(offset);
                    o_div_req.divisor  = i_cfg.sector_bytes;
                end
            end
            S_READ: begin
                o_mem_req.rd_en   = 1'b1;
                o_mem_req.rd_addr = r_idx[fsw_pkg::IdxW-1:0];
            end
            S_UPD: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = r_idx[fsw_pkg::IdxW-1:0];
                o_mem_req.wr_data = i_mem_rdata + 1'b1;
            end
            S_SCAN: begin
                o_mem_req.rd_en   = scan_issue;
                o_mem_req.rd_addr = r_scan[fsw_pkg::IdxW-1:0];
                if (scan_done && (i_cfg.rated != '0)) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = usage_num;
                    o_div_req.divisor  = i_cfg.rated;
                end
            end
            default: begin
            end
        endcase
    end

    // State and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_health  <= fsw_pkg::HealthFull;
            r_acc_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_addr  <= i_addr;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_now <= '0;
                    if (outside) begin
                        r_status <= fsw_pkg::ST_OUTSIDE;
                        r_idx    <= '0;
                        r_state  <= S_OUT;
                    end else if (i_cfg.sector_bytes == '0) begin
                        r_idx   <= '0;
                        r_state <= S_RANGE;
                    end else begin
                        r_state <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    if (i_div_rsp.done) begin
                        r_idx   <= i_div_rsp.quotient[fsw_pkg::DataW-1:0];
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (r_idx >= fsw_pkg::DataW'(eff_tracked)) begin
                        r_status <= fsw_pkg::ST_BEYOND;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= fsw_pkg::ST_COUNTED;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_now     <= i_mem_rdata + 1'b1;
                    r_total   <= r_total + 1'b1;
                    r_scan    <= '0;
                    r_acc_vld <= 1'b0;
                    r_hi      <= '0;
                    r_lo      <= '1;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    r_acc_vld <= scan_issue;
                    if (scan_issue) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (r_acc_vld) begin
                        if (i_mem_rdata > r_hi) begin
                            r_hi <= i_mem_rdata;
                        end
                        if (i_mem_rdata < r_lo) begin
                            r_lo <= i_mem_rdata;
                        end
                    end
                    if (scan_done) begin
                        r_max   <= r_hi;
                        r_min   <= r_lo;
                        r_state <= (i_cfg.rated != '0) ? S_HDIV : S_OUT;
                    end
                end
                S_HDIV: begin
                    if (i_div_rsp.done) begin
                        r_health <= health_calc;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_res_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_OUT);

    always_comb begin
        o_res.status           = r_status;
        o_res.sector_num       = r_idx;
        o_res.sector_count_now = r_now;
        o_res.worst_count      = r_max;
        o_res.least_count      = r_min;
        o_res.erase_total      = r_total;
        o_res.health           = r_health;
    end

endmodule

`default_nettype wire

// ===== design/fsw_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fsw_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_in_valid,
    input wire                            i_in_ready,
    input wire                            i_out_valid,
    input wire                            i_out_ready,
    input wire [1:0]                      i_status,
    input wire [fsw_pkg::DataW-1:0]       i_sector_count_now,
    input wire [fsw_pkg::DataW-1:0]       i_worst_count,
    input wire [fsw_pkg::DataW-1:0]       i_least_count,
    input wire [fsw_pkg::HealthW-1:0]     i_health
);

    // A shown item stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // Only one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // Health stays a percentage
    a_health_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_health <= fsw_pkg::HealthFull))
        else $error("health above full scale");

    // Rejected erases report no sector count
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != fsw_pkg::ST_COUNTED) |-> (i_sector_count_now == '0))
        else $error("rejected erase carries a count");

    // A counted sector is part of the rescan
    a_counted_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == fsw_pkg::ST_COUNTED)
        |-> (i_worst_count >= i_sector_count_now) && (i_worst_count >= i_least_count))
        else $error("worst count below sector or least count");

endmodule

bind flash_sector_wear_tracker_unit fsw_chk u_fsw_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_erase.valid),
    .i_in_ready         (i_erase.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_status           (o_result.status),
    .i_sector_count_now (o_result.sector_count_now),
    .i_worst_count      (o_result.worst_count),
    .i_least_count      (o_result.least_count),
    .i_health           (o_result.health)
);

`default_nettype wire
